// ===== hw/rtl/evf_pkg.sv =====
// shared constants, types and arithmetic helpers of the volume flux block
`timescale 1ns / 1ps
package evf_pkg;
  localparam int FRAC_BITS = 16;
  localparam int GM1_FRAC = 16;
  localparam int W = 32;
  localparam int GW = 17;
  localparam int QW = W + FRAC_BITS;            // widened quotient numerator
  localparam logic [GW-1:0] C_GM1 = 17'd26214;
  localparam logic signed [W-1:0] C_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [W-1:0] C_HALF = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [W-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] SMIN = 32'sh80000000;
  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_RHO = 2'd1;
  localparam logic [1:0] ERR_SAT = 2'd2;

  typedef logic signed [W-1:0] q_t;

  typedef struct packed {
    q_t v;
    logic s;
  } qs_t;

  typedef struct packed {
    q_t density;
    q_t momentum_x;
    q_t momentum_y;
    q_t total_energy;
    q_t jacobian_det;
    q_t dr_dx;
    q_t dr_dy;
    q_t ds_dx;
    q_t ds_dy;
    q_t quad_weight;
  } in_t;

  typedef struct packed {
    q_t flux_r_mass;
    q_t flux_r_xmom;
    q_t flux_r_ymom;
    q_t flux_r_energy;
    q_t flux_s_mass;
    q_t flux_s_xmom;
    q_t flux_s_ymom;
    q_t flux_s_energy;
    logic [1:0] error_flag;
  } out_t;

  function automatic qs_t sat66(input logic signed [65:0] x);
    qs_t r;
    if (x > 66'sd2147483647) begin
      r.v = SMAX; r.s = 1'b1;
    end else if (x < -66'sd2147483648) begin
      r.v = SMIN; r.s = 1'b1;
    end else begin
      r.v = x[W-1:0]; r.s = 1'b0;
    end
    return r;
  endfunction

  function automatic qs_t mulq(input q_t a, input q_t b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + (66'sd1 <<< (FRAC_BITS - 1));
    return sat66(p >>> FRAC_BITS);
  endfunction

  function automatic qs_t mulg(input logic [GW-1:0] g, input q_t b);
    logic signed [65:0] p;
    p = 66'($signed({1'b0, g})) * 66'(b) + (66'sd1 <<< (GM1_FRAC - 1));
    return sat66(p >>> GM1_FRAC);
  endfunction

  function automatic qs_t addq(input q_t a, input q_t b);
    return sat66(66'(a) + 66'(b));
  endfunction
endpackage

// ===== hw/rtl/evf_if.sv =====
// valid/ready channel interfaces for points, results and configuration
`timescale 1ns / 1ps
interface evf_in_if;
  logic valid;
  logic ready;
  evf_pkg::in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface evf_out_if;
  logic valid;
  logic ready;
  evf_pkg::out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface evf_cfg_if;
  logic valid;
  logic ready;
  logic [evf_pkg::GW-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/evf_div.sv =====
// pipelined signed divider, four quotient bits per register stage, result saturated to 32 bits
`timescale 1ns / 1ps
module evf_div (
  input  logic clk,
  input  logic en,
  input  evf_pkg::q_t num,
  input  evf_pkg::q_t den,
  output evf_pkg::qs_t quo
);
  localparam int N = evf_pkg::QW;
  localparam int NS = N / 4;              // four quotient bits per register stage

  logic [N-1:0] rem_q [NS];
  logic [N-1:0] dvd [NS];
  logic [31:0] dsr [NS];
  logic neg [NS];
  logic [N-1:0] rem_nx [NS];
  logic [N-1:0] dvd_nx [NS];
  logic [N-1:0] mag;

  // four restoring steps: shift in the next dividend bit, subtract when it fits
  function automatic logic [2*N-1:0] step4(input logic [N-1:0] r_in, input logic [N-1:0] d_in,
                                           input logic [31:0] ds);
    logic [N-1:0] r_c, d_c;
    logic [N:0] t;
    r_c = r_in;
    d_c = d_in;
    for (int b = 0; b < 4; b++) begin
      t = {r_c, d_c[N-1]};
      d_c = d_c << 1;
      if (t >= (N+1)'(ds)) begin
        r_c = N'(t - (N+1)'(ds));
        d_c[0] = 1'b1;
      end else begin
        r_c = t[N-1:0];
      end
    end
    return {r_c, d_c};
  endfunction

  always_comb begin
    mag = num[31] ? N'(-$signed(N'(num))) : N'(num);
  end

  always_comb begin
    {rem_nx[0], dvd_nx[0]} = step4('0, mag << evf_pkg::FRAC_BITS, den);
    for (int s = 1; s < NS; s++)
      {rem_nx[s], dvd_nx[s]} = step4(rem_q[s-1], dvd[s-1], dsr[s-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s] <= rem_nx[s];
        dvd[s] <= dvd_nx[s];
      end
      dsr[0] <= den;
      neg[0] <= num[31];
      for (int s = 1; s < NS; s++) begin
        dsr[s] <= dsr[s-1];
        neg[s] <= neg[s-1];
      end
    end
  end

  always_comb begin
    logic signed [65:0] q;
    q = neg[NS-1] ? -66'(dvd[NS-1]) : 66'(dvd[NS-1]);
    quo = evf_pkg::sat66(q);
  end
endmodule

// ===== hw/rtl/euler_volume_flux_point.sv =====
// top level: euler volume flux of one quadrature point
// pipeline: 12 divider stages plus 6 arithmetic stages from input request to result
// throughput: one point per cycle; the whole pipeline advances when the output stage can move
// the divider's four quotient bits per stage set the depth
// reset: synchronous, clears valid bits and restores gamma_minus_one to 0.4
`timescale 1ns / 1ps
module euler_volume_flux_point (
  input  logic clk,
  input  logic rst,
  evf_in_if.sink  in_ch,
  evf_out_if.source out_ch,
  evf_cfg_if.sink cfg
);
  localparam int DL = evf_pkg::QW / 4;
  localparam int NP = DL + 6;

  logic [evf_pkg::GW-1:0] gm1;
  logic en;
  logic [NP-1:0] vld;

  assign en = !vld[NP-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gm1 <= evf_pkg::C_GM1;
      vld <= '0;
    end else begin
      if (cfg.valid) gm1 <= cfg.data;
      if (en) vld <= {vld[NP-2:0], in_ch.valid};
    end
  end

  // dividers
  evf_pkg::qs_t u_d, v_d;
  evf_div u_div (.clk, .en, .num(in_ch.data.momentum_x), .den(in_ch.data.density), .quo(u_d));
  evf_div v_div (.clk, .en, .num(in_ch.data.momentum_y), .den(in_ch.data.density), .quo(v_d));

  // delay line for the input and weights alongside the divider
  evf_pkg::in_t dly [DL];
  evf_pkg::qs_t w_q;
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= in_ch.data;
      for (int i = 1; i < DL; i++) dly[i] <= dly[i-1];
    end
  end

  // weights: w in stage 1, metric products computed later from delayed w
  evf_pkg::qs_t wd [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      wd[0] <= evf_pkg::mulq(in_ch.data.jacobian_det, in_ch.data.quad_weight);
      for (int i = 1; i < DL; i++) wd[i] <= wd[i-1];
    end
  end
  assign w_q = wd[DL-1];

  evf_pkg::in_t x1, x2, x3, x4, x5;
  // stage a: products with u, v and metric weights
  evf_pkg::qs_t a_umx, a_vmy, a_vmx, a_umy, a_u, a_v;
  evf_pkg::qs_t a_wrx, a_wry, a_wsx, a_wsy;
  logic a_w;
  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= dly[DL-1];
      a_u <= u_d; a_v <= v_d; a_w <= w_q.s;
      a_umx <= evf_pkg::mulq(u_d.v, dly[DL-1].momentum_x);
      a_vmy <= evf_pkg::mulq(v_d.v, dly[DL-1].momentum_y);
      a_vmx <= evf_pkg::mulq(v_d.v, dly[DL-1].momentum_x);
      a_umy <= evf_pkg::mulq(u_d.v, dly[DL-1].momentum_y);
      a_wrx <= evf_pkg::mulq(w_q.v, dly[DL-1].dr_dx);
      a_wry <= evf_pkg::mulq(w_q.v, dly[DL-1].dr_dy);
      a_wsx <= evf_pkg::mulq(w_q.v, dly[DL-1].ds_dx);
      a_wsy <= evf_pkg::mulq(w_q.v, dly[DL-1].ds_dy);
    end
  end
  logic a_sat;
  assign a_sat = a_u.s | a_v.s | a_w | a_umx.s | a_vmy.s | a_vmx.s | a_umy.s
               | a_wrx.s | a_wry.s | a_wsx.s | a_wsy.s;

  // stage b: u*mx + v*my and half of it, the kinetic energy
  evf_pkg::qs_t b_ke, b_hk;
  evf_pkg::q_t b_umx, b_vmy, b_vmx, b_umy, b_u, b_v, b_wrx, b_wry, b_wsx, b_wsy;
  always_comb begin
    b_ke = evf_pkg::addq(a_umx.v, a_vmy.v);
    b_hk = evf_pkg::mulq(evf_pkg::C_HALF, b_ke.v);
  end
  evf_pkg::qs_t c_hk;
  logic c_sat;
  always_ff @(posedge clk) begin
    if (en) begin
      x2 <= x1;
      c_hk <= b_hk;
      c_sat <= a_sat | b_ke.s;
      b_umx <= a_umx.v; b_vmy <= a_vmy.v; b_vmx <= a_vmx.v; b_umy <= a_umy.v;
      b_u <= a_u.v; b_v <= a_v.v;
      b_wrx <= a_wrx.v; b_wry <= a_wry.v; b_wsx <= a_wsx.v; b_wsy <= a_wsy.v;
    end
  end

  // stage c: pressure
  evf_pkg::qs_t c_in, c_p;
  evf_pkg::q_t c_umx, c_vmy, c_vmx, c_umy, c_u, c_v, c_wrx, c_wry, c_wsx, c_wsy;
  always_comb begin
    c_in = evf_pkg::addq(x2.total_energy, -c_hk.v);
    // negating the most negative half-energy overflows, so that case adds 2^31 exactly and saturates
    if (c_hk.v == evf_pkg::SMIN)
      c_in = evf_pkg::sat66(66'(x2.total_energy) + 66'sd2147483648);
    c_p = evf_pkg::mulg(gm1, c_in.v);
  end
  evf_pkg::qs_t d_p;
  logic d_sat;
  always_ff @(posedge clk) begin
    if (en) begin
      x3 <= x2;
      d_p <= c_p;
      d_sat <= c_sat | c_hk.s | c_in.s;
      c_umx <= b_umx; c_vmy <= b_vmy; c_vmx <= b_vmx; c_umy <= b_umy;
      c_u <= b_u; c_v <= b_v;
      c_wrx <= b_wrx; c_wry <= b_wry; c_wsx <= b_wsx; c_wsy <= b_wsy;
    end
  end

  // stage d: fluxes with pressure
  evf_pkg::qs_t d_fx1, d_fy2, d_ep;
  always_comb begin
    d_fx1 = evf_pkg::addq(c_umx, d_p.v);
    d_fy2 = evf_pkg::addq(c_vmy, d_p.v);
    d_ep = evf_pkg::addq(x3.total_energy, d_p.v);
  end
  evf_pkg::q_t fx [4], fy [4];
  evf_pkg::q_t fxr [3], fyr [3];
  evf_pkg::q_t e_wrx, e_wry, e_wsx, e_wsy;
  evf_pkg::qs_t e_fx3, e_fy3;
  logic e_sat;
  always_ff @(posedge clk) begin
    if (en) begin
      x4 <= x3;
      fxr[0] <= x3.momentum_x; fxr[1] <= d_fx1.v; fxr[2] <= c_vmx;
      fyr[0] <= x3.momentum_y; fyr[1] <= c_umy; fyr[2] <= d_fy2.v;
      e_fx3 <= evf_pkg::mulq(c_u, d_ep.v);
      e_fy3 <= evf_pkg::mulq(c_v, d_ep.v);
      e_wrx <= c_wrx; e_wry <= c_wry; e_wsx <= c_wsx; e_wsy <= c_wsy;
      e_sat <= d_sat | d_p.s | d_fx1.s | d_fy2.s | d_ep.s;
    end
  end
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fx[k] = fxr[k];
      fy[k] = fyr[k];
    end
    fx[3] = e_fx3.v;
    fy[3] = e_fy3.v;
  end

  // stage e: metric products
  evf_pkg::qs_t pr [8], ps [8];
  logic f_sat;
  always_ff @(posedge clk) begin
    if (en) begin
      x5 <= x4;
      f_sat <= e_sat | e_fx3.s | e_fy3.s;
      for (int k = 0; k < 4; k++) begin
        pr[2*k]   <= evf_pkg::mulq(fx[k], e_wrx);
        pr[2*k+1] <= evf_pkg::mulq(fy[k], e_wry);
        ps[2*k]   <= evf_pkg::mulq(fx[k], e_wsx);
        ps[2*k+1] <= evf_pkg::mulq(fy[k], e_wsy);
      end
    end
  end

  // stage f: sums, special cases, output register
  evf_pkg::qs_t rs [4], ss [4];
  logic g_sat;
  always_comb begin
    g_sat = f_sat;
    for (int k = 0; k < 4; k++) begin
      rs[k] = evf_pkg::addq(pr[2*k].v, pr[2*k+1].v);
      ss[k] = evf_pkg::addq(ps[2*k].v, ps[2*k+1].v);
      g_sat = g_sat | pr[2*k].s | pr[2*k+1].s | ps[2*k].s | ps[2*k+1].s | rs[k].s | ss[k].s;
    end
  end
  evf_pkg::out_t res;
  always_ff @(posedge clk) begin
    if (en) begin
      if (x5.density <= 0) begin
        res.flux_r_mass <= '0; res.flux_r_xmom <= '0;
        res.flux_r_ymom <= '0; res.flux_r_energy <= '0;
        res.flux_s_mass <= '0; res.flux_s_xmom <= '0;
        res.flux_s_ymom <= '0; res.flux_s_energy <= '0;
        res.error_flag <= evf_pkg::ERR_RHO;
      end else begin
        res.flux_r_mass <= rs[0].v; res.flux_r_xmom <= rs[1].v;
        res.flux_r_ymom <= rs[2].v; res.flux_r_energy <= rs[3].v;
        res.flux_s_mass <= ss[0].v; res.flux_s_xmom <= ss[1].v;
        res.flux_s_ymom <= ss[2].v; res.flux_s_energy <= ss[3].v;
        res.error_flag <= g_sat ? evf_pkg::ERR_SAT : evf_pkg::ERR_OK;
      end
    end
  end
  assign out_ch.valid = vld[NP-1];
  assign out_ch.data = res;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.error_flag != 2'd3)
    else $error("bad error code");
`endif
endmodule

// ===== bench/evf_flux_checker.sv =====
// checker for the volume flux block: watches the channels, predicts fluxes and compares
`timescale 1ns / 1ps
module evf_flux_checker (
  input  logic clk,
  input  logic rst,
  evf_in_if    pts,
  evf_out_if   fluxes,
  evf_cfg_if   gm1_wr,
  output int   mismatches,
  output int   outstanding
);
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  logic [evf_pkg::GW-1:0] gm1;
  evf_pkg::out_t flux_queue[$];

  function automatic longint clip32(input longint x, inout bit clipped);
    if (x > QMAX) begin
      clipped = 1'b1;
      return QMAX;
    end
    if (x < QMIN) begin
      clipped = 1'b1;
      return QMIN;
    end
    return x;
  endfunction

  // rounded fixed-point product, floor shift
  function automatic longint fmul(input longint a, input longint b, input int sh,
                                  inout bit clipped);
    longint p;
    p = a * b + (64'sd1 <<< (sh - 1));
    return clip32(p >>> sh, clipped);
  endfunction

  function automatic longint fadd(input longint a, input longint b, inout bit clipped);
    return clip32(a + b, clipped);
  endfunction

  function automatic evf_pkg::out_t point_flux(input evf_pkg::in_t p,
                                               input logic [evf_pkg::GW-1:0] g);
    evf_pkg::out_t o;
    bit c;
    longint rho, mx, my, en, w, wrx, wry, wsx, wsy, u, v, ke, inner, pr, ep;
    longint fx[4], fy[4], r[4], s[4];
    c = 1'b0;
    o = '0;
    rho = longint'(p.density);
    mx = longint'(p.momentum_x);
    my = longint'(p.momentum_y);
    en = longint'(p.total_energy);
    if (rho <= 0) begin
      o.error_flag = evf_pkg::ERR_RHO;
      return o;
    end
    w = fmul(longint'(p.jacobian_det), longint'(p.quad_weight), evf_pkg::FRAC_BITS, c);
    wrx = fmul(w, longint'(p.dr_dx), evf_pkg::FRAC_BITS, c);
    wry = fmul(w, longint'(p.dr_dy), evf_pkg::FRAC_BITS, c);
    wsx = fmul(w, longint'(p.ds_dx), evf_pkg::FRAC_BITS, c);
    wsy = fmul(w, longint'(p.ds_dy), evf_pkg::FRAC_BITS, c);
    u = clip32((mx <<< evf_pkg::FRAC_BITS) / rho, c);
    v = clip32((my <<< evf_pkg::FRAC_BITS) / rho, c);
    ke = fadd(fmul(u, mx, evf_pkg::FRAC_BITS, c), fmul(v, my, evf_pkg::FRAC_BITS, c), c);
    inner = fadd(en, -fmul(longint'(evf_pkg::C_HALF), ke, evf_pkg::FRAC_BITS, c), c);
    pr = fmul(longint'(g), inner, evf_pkg::GM1_FRAC, c);
    ep = fadd(en, pr, c);
    fx[0] = mx;
    fx[1] = fadd(fmul(u, mx, evf_pkg::FRAC_BITS, c), pr, c);
    fx[2] = fmul(v, mx, evf_pkg::FRAC_BITS, c);
    fx[3] = fmul(u, ep, evf_pkg::FRAC_BITS, c);
    fy[0] = my;
    fy[1] = fmul(u, my, evf_pkg::FRAC_BITS, c);
    fy[2] = fadd(fmul(v, my, evf_pkg::FRAC_BITS, c), pr, c);
    fy[3] = fmul(v, ep, evf_pkg::FRAC_BITS, c);
    for (int k = 0; k < 4; k++) begin
      r[k] = fadd(fmul(fx[k], wrx, evf_pkg::FRAC_BITS, c),
                  fmul(fy[k], wry, evf_pkg::FRAC_BITS, c), c);
      s[k] = fadd(fmul(fx[k], wsx, evf_pkg::FRAC_BITS, c),
                  fmul(fy[k], wsy, evf_pkg::FRAC_BITS, c), c);
    end
    o.flux_r_mass = evf_pkg::q_t'(r[0]);
    o.flux_r_xmom = evf_pkg::q_t'(r[1]);
    o.flux_r_ymom = evf_pkg::q_t'(r[2]);
    o.flux_r_energy = evf_pkg::q_t'(r[3]);
    o.flux_s_mass = evf_pkg::q_t'(s[0]);
    o.flux_s_xmom = evf_pkg::q_t'(s[1]);
    o.flux_s_ymom = evf_pkg::q_t'(s[2]);
    o.flux_s_energy = evf_pkg::q_t'(s[3]);
    o.error_flag = c ? evf_pkg::ERR_SAT : evf_pkg::ERR_OK;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic cmp(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    evf_pkg::out_t want, got;
    if (rst) begin
      gm1 <= evf_pkg::C_GM1;
    end else begin
      if (gm1_wr.valid && gm1_wr.ready) gm1 <= gm1_wr.data;
      if (pts.valid && pts.ready) flux_queue.push_back(point_flux(pts.data, gm1));
      if (fluxes.valid && fluxes.ready) begin
        got = fluxes.data;
        if (flux_queue.size() == 0) begin
          report_mismatch("unexpected result, error_flag", got.error_flag, -1);
        end else begin
          want = flux_queue.pop_front();
          cmp("flux_r_mass", got.flux_r_mass, want.flux_r_mass);
          cmp("flux_r_xmom", got.flux_r_xmom, want.flux_r_xmom);
          cmp("flux_r_ymom", got.flux_r_ymom, want.flux_r_ymom);
          cmp("flux_r_energy", got.flux_r_energy, want.flux_r_energy);
          cmp("flux_s_mass", got.flux_s_mass, want.flux_s_mass);
          cmp("flux_s_xmom", got.flux_s_xmom, want.flux_s_xmom);
          cmp("flux_s_ymom", got.flux_s_ymom, want.flux_s_ymom);
          cmp("flux_s_energy", got.flux_s_energy, want.flux_s_energy);
          cmp("error_flag", got.error_flag, want.error_flag);
        end
      end
    end
    outstanding = flux_queue.size();
  end
endmodule

// ===== bench/euler_volume_flux_point_tb.sv =====
// testbench top: drives points and gamma writes into the volume flux block, gives the verdict
`timescale 1ns / 1ps
module euler_volume_flux_point_tb;
  logic clk;
  logic rst;
  int mismatches, outstanding;
  int send_idle, recv_idle;
  bit hold_req, hold_done;

  evf_in_if  pts ();
  evf_out_if fluxes ();
  evf_cfg_if gm1_wr ();

  euler_volume_flux_point uut (
    .clk(clk), .rst(rst), .in_ch(pts), .out_ch(fluxes), .cfg(gm1_wr)
  );

  evf_flux_checker chk (
    .clk(clk), .rst(rst), .pts(pts), .fluxes(fluxes), .gm1_wr(gm1_wr),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_cycles;
    fluxes.ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        fluxes.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 80) begin
          @(negedge clk);
          hold_cycles++;
        end
        hold_done <= 1'b1;
      end
      fluxes.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic evf_pkg::q_t rnd_q(input int lo, input int hi);
    return evf_pkg::q_t'($urandom_range(hi - lo) + lo);
  endfunction

  function automatic evf_pkg::in_t sane_point();
    evf_pkg::in_t p;
    p.density = rnd_q(16384, 524288);
    p.momentum_x = rnd_q(-262144, 262144);
    p.momentum_y = rnd_q(-262144, 262144);
    p.total_energy = rnd_q(65536, 1310720);
    p.jacobian_det = rnd_q(6554, 131072);
    p.dr_dx = rnd_q(-131072, 131072);
    p.dr_dy = rnd_q(-131072, 131072);
    p.ds_dx = rnd_q(-131072, 131072);
    p.ds_dy = rnd_q(-131072, 131072);
    p.quad_weight = rnd_q(0, 65536);
    return p;
  endfunction

  function automatic evf_pkg::in_t noise_point();
    evf_pkg::in_t p;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom};
    return p;
  endfunction

  function automatic evf_pkg::in_t random_point();
    evf_pkg::in_t p;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) p = sane_point();
    else if (pick < 85) p = noise_point();
    else begin
      // well-formed but one field pushed to a random large value, or density made zero or negative
      p = sane_point();
      case ($urandom_range(3))
        0: p.momentum_x = evf_pkg::q_t'($urandom);
        1: p.total_energy = evf_pkg::q_t'($urandom);
        2: p.jacobian_det = evf_pkg::q_t'($urandom);
        default: p.density = -evf_pkg::q_t'($urandom_range(65536));
      endcase
    end
    return p;
  endfunction

  task automatic send_point(input evf_pkg::in_t p);
    while ($urandom_range(99) < send_idle) begin
      pts.valid <= 1'b0;
      @(negedge clk);
    end
    pts.valid <= 1'b1;
    pts.data <= p;
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    pts.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_gm1(input logic [evf_pkg::GW-1:0] g);
    drain();
    gm1_wr.valid <= 1'b1;
    gm1_wr.data <= g;
    @(posedge clk);
    while (!gm1_wr.ready) @(posedge clk);
    @(negedge clk);
    gm1_wr.valid <= 1'b0;
  endtask

  initial begin
    evf_pkg::in_t p;
    logic [evf_pkg::GW-1:0] gm1_set[4];
    rst = 1'b1;
    pts.valid = 1'b0;
    pts.data = '0;
    gm1_wr.valid = 1'b0;
    gm1_wr.data = '0;
    send_idle = 34;
    recv_idle = 83;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset gamma, density edge cases, field extremes
    p = sane_point();
    send_point(p);
    p.density = '0;
    send_point(p);
    p.density = evf_pkg::q_t'(-65536);
    send_point(p);
    p.density = evf_pkg::SMIN;
    send_point(p);
    p.density = 32'sd1;
    send_point(p);
    p.density = evf_pkg::SMAX;
    send_point(p);
    p = {10{evf_pkg::SMAX}};
    send_point(p);
    p = {10{evf_pkg::SMIN}};
    p.density = 32'sd1;
    send_point(p);
    p = sane_point();
    p.momentum_x = evf_pkg::SMAX;
    p.momentum_y = evf_pkg::SMIN;
    send_point(p);
    p = sane_point();
    p.total_energy = evf_pkg::SMIN;
    send_point(p);
    p = sane_point();
    p.quad_weight = '0;
    send_point(p);
    p = sane_point();
    p.momentum_x = '0;
    p.momentum_y = '0;
    send_point(p);
    p = sane_point();
    p.jacobian_det = evf_pkg::SMAX;
    p.quad_weight = evf_pkg::SMAX;
    send_point(p);

    gm1_set[0] = '0;
    gm1_set[1] = 17'd131071;
    gm1_set[2] = 17'd65536;
    gm1_set[3] = evf_pkg::GW'($urandom_range(65536));
    for (int ph = 0; ph < 4; ph++) begin
      write_gm1(gm1_set[ph]);
      p = sane_point();
      send_point(p);
      p.total_energy = evf_pkg::SMAX;
      send_point(p);
      for (int i = 0; i < 95; i++) begin
        if (ph == 1) begin
          send_idle = 83;
          recv_idle = 34;
        end else if (ph >= 2) begin
          send_idle = 0;
          recv_idle = 0;
        end
        // long result stall while points keep coming
        if (ph == 2 && i == 20) hold_req <= 1'b1;
        // sender waits for every result to come back
        if (ph == 3 && i == 50) drain();
        send_point(random_point());
      end
    end

    pts.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
